/* hdl/aptsch_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned periodic timer scheduler: shared package
// Holds the sequencer states, register map, reset values, the request
// structure of the shared divider and the small arithmetic helpers.
// ----------------------------------------------------------------------------
package aptsch_pkg;

    // Sequencer states, one-hot coded.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_M_DIV  = 8'b0000_0010,
        ST_T_CRC  = 8'b0000_0100,
        ST_T_DIV1 = 8'b0000_1000,
        ST_T_DIV2 = 8'b0001_0000,
        ST_S_DIV  = 8'b0010_0000,
        ST_SLEEP  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MEASURE_PERIOD  = 3'd0;
    localparam logic [2:0] REG_TRANSMIT_PERIOD = 3'd1;
    localparam logic [2:0] REG_SYNC_PERIOD     = 3'd2;
    localparam logic [2:0] REG_TIMER_ENABLE    = 3'd3;
    localparam logic [2:0] REG_DEVICE_ADDRESS  = 3'd4;

    // Enable bit positions.
    localparam int EN_MEASURE  = 0;
    localparam int EN_TRANSMIT = 1;
    localparam int EN_SYNC     = 2;

    // Reset values of the registers.
    localparam logic [31:0] RST_MEASURE_PERIOD  = 32'd300;
    localparam logic [31:0] RST_TRANSMIT_PERIOD = 32'd900;
    localparam logic [31:0] RST_SYNC_PERIOD     = 32'd43200;
    localparam logic [2:0]  RST_TIMER_ENABLE    = 3'd7;
    localparam logic [47:0] RST_DEVICE_ADDRESS  = 48'h0605_0403_0201;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [30:0] SLEEP_CAP  = 31'h7FFF_FFFF;

    // Start request for the shared remainder unit.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    // A zero period behaves as a period of one.
    function automatic logic [31:0] eff_period(input logic [31:0] p);
        eff_period = (p == 32'd0) ? 32'd1 : p;
    endfunction

    // A timer is due when now is strictly past its due time (signed distance).
    function automatic logic is_due(input logic [31:0] nxt, input logic [31:0] now);
        logic [31:0] d;
        d = now - nxt;
        is_due = (d != 32'd0) && !d[31];
    endfunction

    // Time until due, clamped at zero when overdue.
    function automatic logic [30:0] time_left(input logic [31:0] nxt,
                                              input logic [31:0] now);
        logic [31:0] d;
        d = nxt - now;
        time_left = d[31] ? 31'd0 : d[30:0];
    endfunction

    // One byte of the reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_byte = c;
    endfunction

endpackage

/* hdl/aptsch_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder
// of a 32-bit dividend by a nonzero 32-bit divisor after 32 steps.
// ----------------------------------------------------------------------------
module aptsch_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  aptsch_pkg::div_req_t req,
    output logic                done,
    output logic [31:0]         remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] dividend_reg, dividend_next;
    logic [31:0] divisor_reg, divisor_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] partial;
    logic [32:0] diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        partial = {rem_reg, dividend_reg[31]};
        diff    = partial - {1'b0, divisor_reg};
    end

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        if (req.start) begin
            busy_next     = 1'b1;
            count_next    = 5'd31;
            dividend_next = req.dividend;
            divisor_next  = req.divisor;
            rem_next      = 32'd0;
        end else if (busy_reg) begin
            rem_next      = diff[32] ? partial[31:0] : diff[31:0];
            dividend_next = {dividend_reg[30:0], 1'b0};
            count_next    = count_reg - 5'd1;
            if (count_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 5'd0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // The finished remainder is always below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

endmodule

/* hdl/aptsch_crc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offset hash unit
// Byte-serial CRC-32 over the six address bytes and the four stamp bytes,
// lowest byte first; ten steps and a final inversion.
// ----------------------------------------------------------------------------
module aptsch_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] address,
    input  logic [31:0] stamp,
    output logic        done,
    output logic [31:0] crc
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  count_reg, count_next;
    logic [79:0] data_reg, data_next;
    logic [31:0] crc_reg, crc_next;

    // Feed one byte per cycle from the bottom of the message register.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        data_next  = data_reg;
        crc_next   = crc_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = 4'd9;
            data_next  = {stamp, address};
            crc_next   = aptsch_pkg::CRC_INIT;
        end else if (busy_reg) begin
            crc_next   = aptsch_pkg::crc_byte(crc_reg, data_reg[7:0]);
            data_next  = {8'd0, data_reg[79:8]};
            count_next = count_reg - 4'd1;
            if (count_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 4'd0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        crc_reg  <= crc_next;
    end

    assign done = done_reg;
    assign crc  = crc_reg ^ aptsch_pkg::CRC_INIT;

endmodule

/* hdl/aligned_periodic_timer_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned periodic timer scheduler
// Three period-aligned timers (measure, transmit, sync) checked on every
// time tick; reports which fired and how long to sleep until the next one.
// ----------------------------------------------------------------------------
// Usage:
//   A tick is a transfer on the input channel (in_valid, in_stall, now).
//   One result transfer follows on the output channel (out_valid, out_stall)
//   with the due flags, sleep_time and last_measure_time.
//   A small sequencer drives one shared 32-step remainder unit and a
//   byte-serial CRC unit. A tick with no timer firing only runs the
//   sleep scan before its result reaches the output register. Each firing
//   measure or sync timer adds one remainder, and a firing transmit timer
//   adds a CRC and two remainders.
//   in_stall is high while a tick is being worked on; the next tick is
//   taken once the previous result is in the output register.
//   When the receiver stalls, the result holds in the output register;
//   a following tick is still taken and worked on, and waits at the end
//   until the output register is free.
//   Reset clears all due times and the stamp to zero and loads the
//   register defaults; the block is ready in the first cycle after reset.
//   Registers sit on the APB port at byte address 8*index, 64-bit data.
// ----------------------------------------------------------------------------
module aligned_periodic_timer_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Tick input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now,
    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        measure_due,
    output logic        transmit_due,
    output logic        sync_due,
    output logic [30:0] sleep_time,
    output logic [31:0] last_measure_time
);

    aptsch_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [31:0] measure_period_reg;
    logic [31:0] transmit_period_reg;
    logic [31:0] sync_period_reg;
    logic [2:0]  timer_enable_reg;
    logic [47:0] device_address_reg;

    // Timer state
    logic [31:0] measure_next_reg, measure_next_next;
    logic [31:0] transmit_next_reg, transmit_next_next;
    logic [31:0] sync_next_reg, sync_next_next;
    logic [31:0] measure_stamp_reg, measure_stamp_next;

    // Working registers of the current tick
    logic [31:0] now_reg, now_next;
    logic        m_due_reg, m_due_next;
    logic        t_due_reg, t_due_next;
    logic        s_due_reg, s_due_next;
    logic [31:0] base_reg, base_next;
    logic [30:0] sleep_reg, sleep_next;
    logic [1:0]  sleep_idx_reg, sleep_idx_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        o_m_due_reg, o_t_due_reg, o_s_due_reg;
    logic [30:0] o_sleep_reg;
    logic [31:0] o_stamp_reg;
    logic        load;

    // Shared units
    aptsch_pkg::div_req_t div_req;
    logic        div_done;
    logic [31:0] div_rem;
    logic        crc_start;
    logic        crc_done;
    logic [31:0] crc_value;

    logic [31:0] pm_eff, pt_eff, ps_eff;
    logic        cfg_write;
    logic [2:0]  cfg_idx;
    logic        in_take;
    logic        m_hit, t_hit, s_hit;
    logic [31:0] sel_next;
    logic [30:0] tl;

    assign pm_eff = aptsch_pkg::eff_period(measure_period_reg);
    assign pt_eff = aptsch_pkg::eff_period(transmit_period_reg);
    assign ps_eff = aptsch_pkg::eff_period(sync_period_reg);

    // Configuration port decode.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            measure_period_reg  <= aptsch_pkg::RST_MEASURE_PERIOD;
            transmit_period_reg <= aptsch_pkg::RST_TRANSMIT_PERIOD;
            sync_period_reg     <= aptsch_pkg::RST_SYNC_PERIOD;
            timer_enable_reg    <= aptsch_pkg::RST_TIMER_ENABLE;
            device_address_reg  <= aptsch_pkg::RST_DEVICE_ADDRESS;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                aptsch_pkg::REG_MEASURE_PERIOD:  measure_period_reg  <= pwdata[31:0];
                aptsch_pkg::REG_TRANSMIT_PERIOD: transmit_period_reg <= pwdata[31:0];
                aptsch_pkg::REG_SYNC_PERIOD:     sync_period_reg     <= pwdata[31:0];
                aptsch_pkg::REG_TIMER_ENABLE:    timer_enable_reg    <= pwdata[2:0];
                aptsch_pkg::REG_DEVICE_ADDRESS:  device_address_reg  <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            aptsch_pkg::REG_MEASURE_PERIOD:  prdata = {32'd0, measure_period_reg};
            aptsch_pkg::REG_TRANSMIT_PERIOD: prdata = {32'd0, transmit_period_reg};
            aptsch_pkg::REG_SYNC_PERIOD:     prdata = {32'd0, sync_period_reg};
            aptsch_pkg::REG_TIMER_ENABLE:    prdata = {61'd0, timer_enable_reg};
            aptsch_pkg::REG_DEVICE_ADDRESS:  prdata = {16'd0, device_address_reg};
            default:                         prdata = 64'd0;
        endcase
    end

    // Due checks on the incoming tick, all against the stored due times.
    assign in_stall = (state_reg != aptsch_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign m_hit    = timer_enable_reg[aptsch_pkg::EN_MEASURE]
                      && aptsch_pkg::is_due(measure_next_reg, now);
    assign t_hit    = timer_enable_reg[aptsch_pkg::EN_TRANSMIT]
                      && aptsch_pkg::is_due(transmit_next_reg, now);
    assign s_hit    = timer_enable_reg[aptsch_pkg::EN_SYNC]
                      && aptsch_pkg::is_due(sync_next_reg, now);

    // Sleep scan: one timer per cycle through a single subtract and compare.
    always_comb
    begin
        case (sleep_idx_reg)
            2'd0:    sel_next = measure_next_reg;
            2'd1:    sel_next = transmit_next_reg;
            default: sel_next = sync_next_reg;
        endcase
        tl = aptsch_pkg::time_left(sel_next, now_reg);
    end

    assign load = (state_reg == aptsch_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);

    // Sequencer.
    always_comb
    begin
        state_next         = state_reg;
        now_next           = now_reg;
        m_due_next         = m_due_reg;
        t_due_next         = t_due_reg;
        s_due_next         = s_due_reg;
        base_next          = base_reg;
        sleep_next         = sleep_reg;
        sleep_idx_next     = sleep_idx_reg;
        measure_next_next  = measure_next_reg;
        transmit_next_next = transmit_next_reg;
        sync_next_next     = sync_next_reg;
        measure_stamp_next = measure_stamp_reg;

        unique case (state_reg)
            aptsch_pkg::ST_IDLE:
            begin
                if (in_take) begin
                    now_next       = now;
                    m_due_next     = m_hit;
                    t_due_next     = t_hit;
                    s_due_next     = s_hit;
                    sleep_next     = aptsch_pkg::SLEEP_CAP;
                    sleep_idx_next = 2'd0;
                    if (m_hit)
                        state_next = aptsch_pkg::ST_M_DIV;
                    else if (t_hit)
                        state_next = aptsch_pkg::ST_T_CRC;
                    else if (s_hit)
                        state_next = aptsch_pkg::ST_S_DIV;
                    else
                        state_next = aptsch_pkg::ST_SLEEP;
                end
            end
            aptsch_pkg::ST_M_DIV:
            begin
                if (div_done) begin
                    measure_next_next  = now_reg - div_rem + pm_eff;
                    measure_stamp_next = now_reg;
                    if (t_due_reg)
                        state_next = aptsch_pkg::ST_T_CRC;
                    else if (s_due_reg)
                        state_next = aptsch_pkg::ST_S_DIV;
                    else
                        state_next = aptsch_pkg::ST_SLEEP;
                end
            end
            aptsch_pkg::ST_T_CRC:
            begin
                if (crc_done)
                    state_next = aptsch_pkg::ST_T_DIV1;
            end
            aptsch_pkg::ST_T_DIV1:
            begin
                if (div_done) begin
                    base_next  = now_reg - div_rem + pt_eff;
                    state_next = aptsch_pkg::ST_T_DIV2;
                end
            end
            aptsch_pkg::ST_T_DIV2:
            begin
                if (div_done) begin
                    transmit_next_next = base_reg + div_rem;
                    if (s_due_reg)
                        state_next = aptsch_pkg::ST_S_DIV;
                    else
                        state_next = aptsch_pkg::ST_SLEEP;
                end
            end
            aptsch_pkg::ST_S_DIV:
            begin
                if (div_done) begin
                    sync_next_next = now_reg - div_rem + ps_eff;
                    state_next     = aptsch_pkg::ST_SLEEP;
                end
            end
            aptsch_pkg::ST_SLEEP:
            begin
                if (tl < sleep_reg)
                    sleep_next = tl;
                sleep_idx_next = sleep_idx_reg + 2'd1;
                if (sleep_idx_reg == 2'd2)
                    state_next = aptsch_pkg::ST_EMIT;
            end
            aptsch_pkg::ST_EMIT:
            begin
                if (load)
                    state_next = aptsch_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = aptsch_pkg::ST_IDLE;
            end
        endcase
    end

    // Launch the shared units on entry to the state that waits for them.
    assign crc_start = (state_next == aptsch_pkg::ST_T_CRC)
                       && (state_reg != aptsch_pkg::ST_T_CRC);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = now_reg;
        div_req.divisor  = pm_eff;
        if (state_next != state_reg) begin
            case (state_next)
                aptsch_pkg::ST_M_DIV:
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = (state_reg == aptsch_pkg::ST_IDLE) ? now : now_reg;
                end
                aptsch_pkg::ST_T_DIV1:
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = pt_eff;
                end
                aptsch_pkg::ST_T_DIV2:
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = crc_value;
                    div_req.divisor  = pt_eff;
                end
                aptsch_pkg::ST_S_DIV:
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = (state_reg == aptsch_pkg::ST_IDLE) ? now : now_reg;
                    div_req.divisor  = ps_eff;
                end
                default: ;
            endcase
        end
    end

    aptsch_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    // The hash takes the stamp as it stands after this tick's measure firing.
    aptsch_crc u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (crc_start),
        .address (device_address_reg),
        .stamp   (measure_stamp_next),
        .done    (crc_done),
        .crc     (crc_value)
    );

    // Output valid: set on load, cleared once the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Control and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= aptsch_pkg::ST_IDLE;
            out_valid_reg     <= 1'b0;
            measure_next_reg  <= 32'd0;
            transmit_next_reg <= 32'd0;
            sync_next_reg     <= 32'd0;
            measure_stamp_reg <= 32'd0;
            sleep_idx_reg     <= 2'd0;
        end else begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            measure_next_reg  <= measure_next_next;
            transmit_next_reg <= transmit_next_next;
            sync_next_reg     <= sync_next_next;
            measure_stamp_reg <= measure_stamp_next;
            sleep_idx_reg     <= sleep_idx_next;
        end
    end

    // Working payload of the tick.
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        m_due_reg <= m_due_next;
        t_due_reg <= t_due_next;
        s_due_reg <= s_due_next;
        base_reg  <= base_next;
        sleep_reg <= sleep_next;
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            o_m_due_reg <= m_due_reg;
            o_t_due_reg <= t_due_reg;
            o_s_due_reg <= s_due_reg;
            o_sleep_reg <= sleep_reg;
            o_stamp_reg <= measure_stamp_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign measure_due       = o_m_due_reg;
    assign transmit_due      = o_t_due_reg;
    assign sync_due          = o_s_due_reg;
    assign sleep_time        = o_sleep_reg;
    assign last_measure_time = o_stamp_reg;

    // A remainder only comes back while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == aptsch_pkg::ST_M_DIV
                      || state_reg == aptsch_pkg::ST_T_DIV1
                      || state_reg == aptsch_pkg::ST_T_DIV2
                      || state_reg == aptsch_pkg::ST_S_DIV))
        else $error("remainder returned outside a division state");

    // The hash only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        crc_done |-> (state_reg == aptsch_pkg::ST_T_CRC))
        else $error("hash finished outside the hash state");

    // A measure firing reports the tick's own time as the stamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && m_due_reg) |=> (last_measure_time == $past(now_reg)))
        else $error("measure firing reported a wrong stamp");

endmodule
